[src/idt_pkg.sv]
// ----------------------------------------------------------------------------
// idt_pkg
// Shared constants, operation codes and the table access bundle of the
// instance dependence tracker.
// ----------------------------------------------------------------------------
package idt_pkg;

   localparam int FUNCS      = 16;
   localparam int ENTRIES    = 256;
   localparam int ID_BITS    = 16;
   localparam int ADDR_BITS  = 48;
   localparam int DEPTH_BITS = 16;
   localparam int LINE_BITS  = 31;
   localparam int TAG_BITS   = 16;

   localparam int FUNC_BITS  = $clog2(FUNCS);
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int USED_BITS  = IDX_BITS + 1;
   localparam int WADDR_BITS = IDX_BITS + FUNC_BITS;

   // event codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_ENTRY = 2'd2;
   localparam logic [1:0] OP_EXIT  = 2'd3;

   // report codes
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_RAW  = 2'd1;
   localparam logic [1:0] KIND_WAW  = 2'd2;

   // one cycle of table traffic
   typedef struct packed {
      logic                  addr_we;
      logic [IDX_BITS-1:0]   addr_widx;
      logic [ADDR_BITS-1:0]  addr_wdata;
      logic [IDX_BITS-1:0]   addr_ridx;
      logic                  wr_we;
      logic [WADDR_BITS-1:0] wr_waddr;
      logic [ID_BITS-1:0]    wr_wdata;
      logic [WADDR_BITS-1:0] wr_raddr;
   } tbl_req_type;

endpackage

[src/instance_dependence_tracker.sv]
// ----------------------------------------------------------------------------
// instance_dependence_tracker
// Tracks call instances per function and reports cross-instance
// read-after-write and write-after-write accesses through an address table.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              contents
//  req_     in         req_valid/req_ready    one event word
//  rsp_     out        rsp_valid/rsp_ready    one report word per event
//
//  call entry and non-final exit: the report word is set in the cycle after the word is taken.
//  read/write: linear scan of the address table, one entry per cycle
//  through its read port; a write miss allocates an entry and its writer words.
//  final exit: one writer table write per used entry.
//  reset clears the per-function counters and the fill count; no sweep.
//  a new word is taken only when idle and the report register is empty.
// ----------------------------------------------------------------------------
module instance_dependence_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_operation,
   input  logic [idt_pkg::FUNC_BITS-1:0]      req_func_index,
   input  logic [idt_pkg::ADDR_BITS-1:0]      req_address,
   input  logic [idt_pkg::LINE_BITS-1:0]      req_line_id,
   input  logic [idt_pkg::TAG_BITS-1:0]       req_var_tag,
   input  logic [idt_pkg::TAG_BITS-1:0]       req_site_tag,
   input  logic                               req_last_call,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_dep_kind,
   output logic [idt_pkg::LINE_BITS-1:0]      rsp_report_line,
   output logic [idt_pkg::TAG_BITS-1:0]       rsp_report_var,
   output logic [idt_pkg::TAG_BITS-1:0]       rsp_report_site,
   output logic                               rsp_table_full
);
   import idt_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_WRD   = 3'd2;
   localparam logic [2:0] S_WCMP  = 3'd3;
   localparam logic [2:0] S_ALLOC = 3'd4;
   localparam logic [2:0] S_CLEAR = 3'd5;

   localparam logic [ID_BITS-1:0]    ID_MAX    = {ID_BITS{1'b1}};
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
   localparam logic [USED_BITS-1:0]  USED_MAX  = USED_BITS'(ENTRIES);
   localparam logic [FUNC_BITS-1:0]  FUNC_LAST = FUNC_BITS'(FUNCS - 1);

   logic [2:0] state_ff, state_in;

   logic [DEPTH_BITS-1:0] depth_ff [FUNCS];
   logic [DEPTH_BITS-1:0] depth_in [FUNCS];
   logic [ID_BITS-1:0]    count_ff [FUNCS];
   logic [ID_BITS-1:0]    count_in [FUNCS];
   logic [ID_BITS-1:0]    inst_ff  [FUNCS];
   logic [ID_BITS-1:0]    inst_in  [FUNCS];
   logic [USED_BITS-1:0]  used_ff, used_in;

   logic [1:0]            op_ff, op_in;
   logic [FUNC_BITS-1:0]  func_ff, func_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic [TAG_BITS-1:0]   var_ff, var_in;
   logic [TAG_BITS-1:0]   site_ff, site_in;
   logic [ID_BITS-1:0]    cur_ff, cur_in;

   logic [USED_BITS-1:0]  scan_ff, scan_in;
   logic                  chk_ff, chk_in;
   logic [IDX_BITS-1:0]   chk_idx_ff, chk_idx_in;
   logic [IDX_BITS-1:0]   hit_ff, hit_in;
   logic [USED_BITS-1:0]  sweep_ff, sweep_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            kind_ff, kind_in;
   logic [LINE_BITS-1:0]  rline_ff, rline_in;
   logic [TAG_BITS-1:0]   rvar_ff, rvar_in;
   logic [TAG_BITS-1:0]   rsite_ff, rsite_in;
   logic                  full_ff, full_in;

   tbl_req_type           tbl_req;
   logic [ADDR_BITS-1:0]  addr_q;
   logic [ID_BITS-1:0]    writer_q;
   logic                  accept;
   logic                  issue;
   logic [DEPTH_BITS-1:0] dec_depth;

   idt_tables u_tables (
      .clock    (clock),
      .tbl_req  (tbl_req),
      .addr_q   (addr_q),
      .writer_q (writer_q)
   );

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign issue     = scan_ff < used_ff;
   assign dec_depth = (depth_ff[req_func_index] != '0) ?
                      depth_ff[req_func_index] - 1'b1 : '0;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      inst_in      = inst_ff;
      used_in      = used_ff;
      op_in        = op_ff;
      func_in      = func_ff;
      addr_in      = addr_ff;
      line_in      = line_ff;
      var_in       = var_ff;
      site_in      = site_ff;
      cur_in       = cur_ff;
      scan_in      = scan_ff;
      chk_in       = chk_ff;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      rline_in     = rline_ff;
      rvar_in      = rvar_ff;
      rsite_in     = rsite_ff;
      full_in      = full_ff;

      tbl_req            = '0;
      tbl_req.addr_ridx  = scan_ff[IDX_BITS-1:0];
      tbl_req.addr_widx  = used_ff[IDX_BITS-1:0];
      tbl_req.addr_wdata = addr_ff;
      tbl_req.wr_raddr   = {hit_ff, func_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_operation;
               func_in = req_func_index;
               addr_in = req_address;
               line_in = req_line_id;
               var_in  = req_var_tag;
               site_in = req_site_tag;
               cur_in  = inst_ff[req_func_index];
               // quiet report by default
               kind_in  = KIND_NONE;
               rline_in = '0;
               rvar_in  = '0;
               rsite_in = '0;
               full_in  = 1'b0;
               unique case (req_operation)
                  OP_ENTRY: begin
                     if (depth_ff[req_func_index] == '0) begin
                        if (count_ff[req_func_index] != ID_MAX) begin
                           count_in[req_func_index] = count_ff[req_func_index] + 1'b1;
                           inst_in[req_func_index]  = count_ff[req_func_index] + 1'b1;
                        end else begin
                           inst_in[req_func_index]  = count_ff[req_func_index];
                        end
                     end
                     if (depth_ff[req_func_index] != DEPTH_MAX) begin
                        depth_in[req_func_index] = depth_ff[req_func_index] + 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_EXIT: begin
                     depth_in[req_func_index] = dec_depth;
                     if (dec_depth == '0 && req_last_call) begin
                        count_in[req_func_index] = '0;
                        inst_in[req_func_index]  = '0;
                        sweep_in = '0;
                        state_in = S_CLEAR;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     if (inst_ff[req_func_index] == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        scan_in  = '0;
                        chk_in   = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            // one read issued and one compare made per cycle
            chk_in     = issue;
            chk_idx_in = scan_ff[IDX_BITS-1:0];
            scan_in    = scan_ff + 1'b1;
            if (chk_ff && addr_q == addr_ff) begin
               hit_in   = chk_idx_ff;
               chk_in   = 1'b0;
               state_in = S_WRD;
            end else if (!issue && !chk_ff) begin
               chk_in = 1'b0;
               if (op_ff == OP_WRITE && used_ff < USED_MAX) begin
                  tbl_req.addr_we = 1'b1;
                  sweep_in = '0;
                  state_in = S_ALLOC;
               end else begin
                  full_in      = (op_ff == OP_WRITE);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         S_WRD: begin
            state_in = S_WCMP;
         end
         S_WCMP: begin
            if (writer_q != cur_ff) begin
               kind_in  = (op_ff == OP_WRITE) ? KIND_WAW : KIND_RAW;
               rline_in = line_ff;
               rvar_in  = var_ff;
               rsite_in = site_ff;
               if (op_ff == OP_WRITE) begin
                  tbl_req.wr_we    = 1'b1;
                  tbl_req.wr_waddr = {hit_ff, func_ff};
                  tbl_req.wr_wdata = cur_ff;
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_ALLOC: begin
            // fresh entry: own function gets the current instance, others zero
            tbl_req.wr_we    = 1'b1;
            tbl_req.wr_waddr = {used_ff[IDX_BITS-1:0], sweep_ff[FUNC_BITS-1:0]};
            tbl_req.wr_wdata = (sweep_ff[FUNC_BITS-1:0] == func_ff) ? cur_ff : '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff[FUNC_BITS-1:0] == FUNC_LAST) begin
               used_in      = used_ff + 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_CLEAR: begin
            // wipe the function's writer column over the used entries
            if (sweep_ff < used_ff) begin
               tbl_req.wr_we    = 1'b1;
               tbl_req.wr_waddr = {sweep_ff[IDX_BITS-1:0], func_ff};
               tbl_req.wr_wdata = '0;
               sweep_in = sweep_ff + 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         chk_ff       <= 1'b0;
         for (int i = 0; i < FUNCS; i++) begin
            depth_ff[i] <= '0;
            count_ff[i] <= '0;
            inst_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_ff       <= chk_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         inst_ff      <= inst_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      func_ff    <= func_in;
      addr_ff    <= addr_in;
      line_ff    <= line_in;
      var_ff     <= var_in;
      site_ff    <= site_in;
      cur_ff     <= cur_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      hit_ff     <= hit_in;
      sweep_ff   <= sweep_in;
      kind_ff    <= kind_in;
      rline_ff   <= rline_in;
      rvar_ff    <= rvar_in;
      rsite_ff   <= rsite_in;
      full_ff    <= full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dep_kind    = kind_ff;
   assign rsp_report_line = rline_ff;
   assign rsp_report_var  = rvar_ff;
   assign rsp_report_site = rsite_ff;
   assign rsp_table_full  = full_ff;

endmodule

[src/idt_tables.sv]
// ----------------------------------------------------------------------------
// idt_tables
// Address table and writer table, each one synchronous memory with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module idt_tables (
   input  logic                               clock,
   input  idt_pkg::tbl_req_type               tbl_req,
   output logic [idt_pkg::ADDR_BITS-1:0]      addr_q,
   output logic [idt_pkg::ID_BITS-1:0]        writer_q
);
   import idt_pkg::*;

   logic [ADDR_BITS-1:0] addr_mem   [ENTRIES];
   logic [ID_BITS-1:0]   writer_mem [ENTRIES*FUNCS];

   // address table
   always_ff @(posedge clock) begin
      if (tbl_req.addr_we) begin
         addr_mem[tbl_req.addr_widx] <= tbl_req.addr_wdata;
      end
      addr_q <= addr_mem[tbl_req.addr_ridx];
   end

   // writer table, one word per entry and function
   always_ff @(posedge clock) begin
      if (tbl_req.wr_we) begin
         writer_mem[tbl_req.wr_waddr] <= tbl_req.wr_wdata;
      end
      writer_q <= writer_mem[tbl_req.wr_raddr];
   end

endmodule

[src/idt_check.sv]
// ----------------------------------------------------------------------------
// idt_check
// Port-level checks on the report channel of the instance dependence tracker.
// ----------------------------------------------------------------------------
module idt_check (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_dep_kind,
   input logic [idt_pkg::LINE_BITS-1:0]      rsp_report_line,
   input logic [idt_pkg::TAG_BITS-1:0]       rsp_report_var,
   input logic [idt_pkg::TAG_BITS-1:0]       rsp_report_site,
   input logic                               rsp_table_full
);
   import idt_pkg::*;

   // a pending report holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("report dropped while stalled");

   // no new word while a report waits
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("word taken with report pending");

   // quiet reports carry no echo
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dep_kind == KIND_NONE |->
         rsp_report_line == '0 && rsp_report_var == '0 && rsp_report_site == '0)
      else $error("echo on empty report");

   // a full table never reports a dependence
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_dep_kind == KIND_NONE)
      else $error("dependence with full table");

   // report code stays in range
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dep_kind == KIND_NONE || rsp_dep_kind == KIND_RAW ||
                    rsp_dep_kind == KIND_WAW)
      else $error("bad report code");

endmodule

bind instance_dependence_tracker idt_check u_idt_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_dep_kind    (rsp_dep_kind),
   .rsp_report_line (rsp_report_line),
   .rsp_report_var  (rsp_report_var),
   .rsp_report_site (rsp_report_site),
   .rsp_table_full  (rsp_table_full)
);
